// ===== rtl/chca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the canonical Huffman code assignment unit.
// No dependencies.
package chca_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam int        K_W         = 7;
    localparam logic [6:0] ROUND_LIMIT = 7'd64;

    typedef enum logic [1:0] {
        KIND_ASSIGN = 2'd0,
        KIND_CLAMP  = 2'd1,
        KIND_REPAIR = 2'd2
    } t_kind;

    typedef struct packed {
        logic  wr_len;
        logic  rd_issue;
        logic  rd_out;
        logic  asg_init;
        logic  rnd_next;
        logic  scan_start;
        logic  scan_down;
        t_kind kind;
        logic  rep_init;
        logic  rk_dec;
        logic  done_out;
    } t_cmd;

    typedef struct packed {
        logic round_stop;
        logic scan_busy;
        logic hit;
        logic rk_zero;
        logic k_gt;
    } t_sts;

endpackage

// ===== rtl/canonical_huffman_code_assign_unit.sv =====
`timescale 1ns / 1ps
// Top level of the canonical Huffman code assignment unit: APB register, sequencer, datapath.
// Depends on chca_pkg, chca_ctrl, chca_dp.
//
// A command is taken when start is high and busy is low. A length write gives no result.
// A read passes through state S_RD, from which its result and strobe are registered.
// A build scans the n active symbols once per length round, with rounds run until the
// counter closes (up to 64); a repair adds one clamp scan, up to CODE_BITS further scans
// and a second full build. Each scan reads the symbols in turn through the one read port
// of each table.
// Each result is on o_valid and the result ports for one cycle and cannot be stalled.
module canonical_huffman_code_assign_unit import chca_pkg::*; #(
    parameter int MAX_SYMBOLS = 512,
    parameter int CODE_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [8:0]  i_symbol,
    input  logic [4:0]  i_code_length,
    output logic        o_valid,
    output logic [15:0] o_code_value,
    output logic [4:0]  o_final_length,
    output logic        o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0] r_symbol_count;
    t_cmd       cmd;
    t_sts       sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= 10'd510;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_symbol_count <= pwdata[9:0];
        end
    end

    assign prdata = paddr[2] ? '0 : 32'(r_symbol_count);
    assign pready = 1'b1;

    chca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    chca_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .CODE_BITS(CODE_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_symbol_count (r_symbol_count),
        .i_symbol       (i_symbol),
        .i_code_length  (i_code_length),
        .o_valid        (o_valid),
        .o_code_value   (o_code_value),
        .o_final_length (o_final_length),
        .o_status       (o_status)
    );

endmodule

// ===== rtl/chca_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module chca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/chca_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for write, read and build commands of the code assignment unit.
// Depends on chca_pkg.
module chca_ctrl import chca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_RCHK  = 6'b000100,
        S_RSCAN = 6'b001000,
        S_FIX   = 6'b010000,
        S_KSCAN = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass2, n_pass2;

    always_comb begin
        n_state = r_state;
        n_pass2 = r_pass2;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_WRITE: o_cmd.wr_len = 1'b1;
                        MODE_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RD;
                        end
                        MODE_BUILD: begin
                            o_cmd.asg_init = 1'b1;
                            n_pass2        = 1'b0;
                            n_state        = S_RCHK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_out = 1'b1;
                n_state      = S_IDLE;
            end
            S_RCHK: begin
                if (i_sts.round_stop) begin
                    if (!r_pass2 && i_sts.k_gt) begin
                        o_cmd.rep_init   = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_down  = 1'b1;
                        o_cmd.kind       = KIND_CLAMP;
                        n_state          = S_FIX;
                    end else begin
                        o_cmd.done_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.rnd_next   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    o_cmd.kind       = KIND_ASSIGN;
                    n_state          = S_RSCAN;
                end
            end
            S_RSCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = S_RCHK;
                end
            end
            S_FIX: begin
                if (!i_sts.scan_busy) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_down  = 1'b1;
                    o_cmd.kind       = KIND_REPAIR;
                    n_state          = S_KSCAN;
                end
            end
            S_KSCAN: begin
                if (!i_sts.scan_busy) begin
                    if (i_sts.hit || i_sts.rk_zero) begin
                        o_cmd.asg_init = 1'b1;
                        n_pass2        = 1'b1;
                        n_state        = S_RCHK;
                    end else begin
                        o_cmd.rk_dec     = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_down  = 1'b1;
                        o_cmd.kind       = KIND_REPAIR;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass2 <= n_pass2;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/chca_dp.sv =====
`timescale 1ns / 1ps
// Datapath: length and code tables, round counters, symbol scanner, repair logic.
// Depends on chca_pkg and chca_ram.
module chca_dp import chca_pkg::*; #(
    parameter int MAX_SYMBOLS = 512,
    parameter int CODE_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [9:0]  i_symbol_count,
    input  logic [8:0]  i_symbol,
    input  logic [4:0]  i_code_length,
    output logic        o_valid,
    output logic [15:0] o_code_value,
    output logic [4:0]  o_final_length,
    output logic        o_status
);

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int NW = $clog2(MAX_SYMBOLS + 1);

    logic [CODE_BITS-1:0] r_cnt, r_lim, r_rcnt;
    logic [K_W-1:0]       r_k;
    logic [4:0]           r_rk;
    logic                 r_hit;
    logic [NW-1:0]        r_left;
    logic [AW-1:0]        r_addr, r_paddr;
    logic                 r_pend, r_down, r_rd_ok;
    t_kind                r_kind;
    logic                 r_valid, r_status;
    logic [15:0]          r_code;
    logic [4:0]           r_len;

    logic                 sym_ok;
    logic [NW-1:0]        n_syms;
    logic [4:0]           len_rd;
    logic [CODE_BITS-1:0] code_rd, rcnt_dec, thr;
    logic [4:0]           sh;
    logic                 asg_match, clamp_match, rep_match, hit_now, issuing;
    logic                 len_we, code_we;
    logic [AW-1:0]        len_waddr, raddr;
    logic [4:0]           len_wdata;

    assign sym_ok  = {2'b00, i_symbol} < 11'(MAX_SYMBOLS);
    assign n_syms  = ({1'b0, i_symbol_count} > 11'(MAX_SYMBOLS)) ?
                     NW'(MAX_SYMBOLS) : NW'(i_symbol_count);
    assign issuing = (r_left != '0);

    assign rcnt_dec    = r_rcnt - 1'b1;
    assign sh          = 5'(CODE_BITS) - r_rk;
    assign thr         = rcnt_dec >> sh;
    assign asg_match   = ({2'b00, len_rd} == r_k);
    assign clamp_match = (len_rd >= 5'(CODE_BITS));
    assign rep_match   = (len_rd == r_rk);
    assign hit_now     = r_pend && (r_kind == KIND_REPAIR) && rep_match && (code_rd <= thr);

    assign len_we    = (i_cmd.wr_len && sym_ok) ||
                       (r_pend && (((r_kind == KIND_CLAMP) && clamp_match) ||
                                   ((r_kind == KIND_REPAIR) && rep_match)));
    assign len_waddr = i_cmd.wr_len ? AW'(i_symbol) : r_paddr;
    assign len_wdata = i_cmd.wr_len ? i_code_length : 5'(CODE_BITS);
    assign raddr     = issuing ? r_addr : AW'(i_symbol);
    assign code_we   = r_pend && (r_kind == KIND_ASSIGN) && asg_match;

    chca_ram #(.WIDTH(5), .DEPTH(MAX_SYMBOLS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (raddr),
        .o_rdata (len_rd)
    );

    chca_ram #(.WIDTH(CODE_BITS), .DEPTH(MAX_SYMBOLS)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (r_paddr),
        .i_wdata (r_cnt),
        .i_raddr (raddr),
        .o_rdata (code_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.asg_init) begin
            r_cnt <= '0;
            r_lim <= CODE_BITS'(1);
            r_k   <= '0;
        end else if (i_cmd.rnd_next) begin
            r_cnt <= r_cnt << 1;
            r_lim <= r_lim << 1;
            r_k   <= r_k + 1'b1;
        end else if (code_we) begin
            r_cnt <= r_cnt + 1'b1;
        end

        if (i_cmd.rep_init) begin
            r_rcnt <= '0;
            r_rk   <= 5'(CODE_BITS - 1);
        end else begin
            if (i_cmd.rk_dec) begin
                r_rk <= r_rk - 1'b1;
            end
            if (len_we && !i_cmd.wr_len) begin
                r_rcnt <= rcnt_dec;
            end
        end

        if (i_cmd.scan_start) begin
            r_kind <= i_cmd.kind;
            r_down <= i_cmd.scan_down;
            r_addr <= i_cmd.scan_down ? AW'(n_syms - NW'(1)) : '0;
        end else if (issuing) begin
            r_paddr <= r_addr;
            r_addr  <= r_down ? r_addr - 1'b1 : r_addr + 1'b1;
        end

        if (i_cmd.rd_issue) begin
            r_rd_ok <= sym_ok;
        end

        if (i_cmd.rd_out) begin
            r_code   <= r_rd_ok ? 16'(code_rd) : '0;
            r_len    <= r_rd_ok ? len_rd : '0;
            r_status <= 1'b0;
        end else if (i_cmd.done_out) begin
            r_code   <= '0;
            r_len    <= '0;
            r_status <= (r_k > K_W'(CODE_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.rd_out || i_cmd.done_out;
            if (i_cmd.rep_init) begin
                r_hit <= 1'b0;
            end else if (hit_now) begin
                r_hit <= 1'b1;
            end
            if (hit_now) begin
                r_left <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_start) begin
                r_left <= n_syms;
                r_pend <= 1'b0;
            end else begin
                r_pend <= issuing;
                if (issuing) begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    assign o_sts.round_stop = (r_cnt == r_lim) || (r_k == ROUND_LIMIT);
    assign o_sts.scan_busy  = issuing || r_pend;
    assign o_sts.hit        = r_hit;
    assign o_sts.rk_zero    = (r_rk == '0);
    assign o_sts.k_gt       = (r_k > K_W'(CODE_BITS));

    assign o_valid        = r_valid;
    assign o_code_value   = r_code;
    assign o_final_length = r_len;
    assign o_status       = r_status;

endmodule

// ===== tb/tb_canonical_huffman_code_assign_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for canonical_huffman_code_assign_unit: length writes, builds, reads,
// symbol_count changes over APB, all checked against a cycle-free model of the code tables.
// Depends on chca_pkg and the unit under test.
module tb_canonical_huffman_code_assign_unit import chca_pkg::*; ();

    localparam int          NSYM       = 512;
    localparam int          CBITS      = 16;
    localparam logic [1:0]  MODE_NONE  = 2'd3;
    localparam logic [2:0]  ADDR_COUNT = 3'd0;
    localparam int          LIMIT      = 3000000;

    typedef struct {
        logic [1:0] mode;
        logic [8:0] sym;
        logic [4:0] len;
    } t_item;

    typedef struct {
        logic [15:0] code;
        logic [4:0]  flen;
        logic        status;
    } t_res;

    logic        i_clk, i_rst_n, start, busy;
    logic [1:0]  i_mode;
    logic [8:0]  i_symbol;
    logic [4:0]  i_code_length;
    logic        o_valid;
    logic [15:0] o_code_value;
    logic [4:0]  o_final_length;
    logic        o_status;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    canonical_huffman_code_assign_unit uut (.*);

    // model state at acceptance (a_), at generation (g_), scratch (w_)
    logic [4:0]  a_len[NSYM], g_len[NSYM], w_len[NSYM];
    logic [15:0] a_code[NSYM], g_code[NSYM], w_code[NSYM];
    bit          a_cw[NSYM], g_cw[NSYM], w_cw[NSYM];
    bit          w_bad;
    int          a_n, g_n;

    t_item pending_cmds[$];
    t_res  expected_results[$];
    int    errs, cyc, gap;
    bit    no_idle;
    t_item cur;

    function automatic int assign_rounds(int n);
        logic [15:0] cnt, lim;
        int k;
        cnt = 16'd0;
        lim = 16'd1;
        k = 0;
        while (cnt != lim && k < 64) begin
            cnt = cnt << 1;
            lim = lim << 1;
            k++;
            for (int s = 0; s < n; s++) begin
                if (w_len[s] == k) begin
                    w_code[s] = cnt;
                    w_cw[s] = 1'b1;
                    cnt = cnt + 16'd1;
                end
            end
        end
        return k;
    endfunction

    function automatic void repair_lengths(int n);
        logic [15:0] cnt;
        logic [63:0] shifted;
        bit done;
        cnt = 16'd0;
        done = 1'b0;
        for (int s = n - 1; s >= 0; s--) begin
            if (w_len[s] >= CBITS) begin
                w_len[s] = 5'(CBITS);
                cnt = cnt - 16'd1;
            end
        end
        for (int k = CBITS - 1; k >= 0 && !done; k--) begin
            for (int s = n - 1; s >= 0 && !done; s--) begin
                if (w_len[s] == k) begin
                    w_len[s] = 5'(CBITS);
                    cnt = cnt - 16'd1;
                    if (!w_cw[s]) w_bad = 1'b1;
                    shifted = 64'(w_code[s]) << (CBITS - k);
                    if (shifted <= 64'(cnt)) done = 1'b1;
                end
            end
        end
    endfunction

    function automatic logic build_codes(int n);
        int ne;
        ne = (n > NSYM) ? NSYM : n;
        if (assign_rounds(ne) <= CBITS) return 1'b0;
        repair_lengths(ne);
        return (assign_rounds(ne) <= CBITS) ? 1'b0 : 1'b1;
    endfunction

    // accepted beat: update the model and queue what it must produce
    function automatic void predict(t_item c);
        t_res r;
        logic st;
        case (c.mode)
            MODE_WRITE: a_len[c.sym] = c.len;
            MODE_BUILD: begin
                for (int s = 0; s < NSYM; s++) begin
                    w_len[s] = a_len[s];
                    w_code[s] = a_code[s];
                    w_cw[s] = a_cw[s];
                end
                st = build_codes(a_n);
                for (int s = 0; s < NSYM; s++) begin
                    a_len[s] = w_len[s];
                    a_code[s] = w_code[s];
                    a_cw[s] = w_cw[s];
                end
                r.code = '0;
                r.flen = '0;
                r.status = st;
                expected_results.push_back(r);
            end
            MODE_READ: begin
                r.code = a_code[c.sym];
                r.flen = a_len[c.sym];
                r.status = 1'b0;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // queue a command unless it would read a table entry never written
    function automatic void add_cmd(logic [1:0] m, int sym, int len);
        t_item c;
        c.mode = m;
        c.sym = sym[8:0];
        c.len = len[4:0];
        if (m == MODE_READ && !g_cw[sym]) return;
        if (m == MODE_WRITE) g_len[sym] = len[4:0];
        if (m == MODE_BUILD) begin
            for (int s = 0; s < NSYM; s++) begin
                w_len[s] = g_len[s];
                w_code[s] = g_code[s];
                w_cw[s] = g_cw[s];
            end
            w_bad = 1'b0;
            void'(build_codes(g_n));
            if (w_bad) return;
            for (int s = 0; s < NSYM; s++) begin
                g_len[s] = w_len[s];
                g_code[s] = w_code[s];
                g_cw[s] = w_cw[s];
            end
        end
        pending_cmds.push_back(c);
    endfunction

    function automatic int rand_len();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 0;
        if (p == 1) return $urandom_range(17, 31);
        return $urandom_range(1, 8);
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || start || busy)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_count(int v);
        wait_idle();
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_COUNT;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        a_n = v & 32'h3FF;
        g_n = v & 32'h3FF;
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // driver: hand out beats, random gaps between them unless no_idle is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                predict(cur);
                if (no_idle) gap = 0;
                else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gap = 0;
                        6, 7, 8: gap = $urandom_range(1, 3);
                        default: gap = $urandom_range(10, 40);
                    endcase
                end
            end
            if (gap > 0) begin
                gap = gap - 1;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur = pending_cmds.pop_front();
                i_mode <= cur.mode;
                i_symbol <= cur.sym;
                i_code_length <= cur.len;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, check each one as it appears
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result code=%h len=%0d status=%0d",
                       o_code_value, o_final_length, o_status);
                errs++;
            end else begin
                e = expected_results.pop_front();
                if (o_code_value !== e.code) begin
                    $error("code_value expected %h actual %h", e.code, o_code_value);
                    errs++;
                end
                if (o_final_length !== e.flen) begin
                    $error("final_length expected %0d actual %0d", e.flen, o_final_length);
                    errs++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    errs++;
                end
            end
        end
    end

    initial begin
        int n, m;
        errs = 0;
        cyc = 0;
        gap = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = MODE_WRITE;
        i_symbol = '0;
        i_code_length = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_COUNT;
        pwdata = '0;
        a_n = 510;
        g_n = 510;
        for (int s = 0; s < NSYM; s++) begin
            a_len[s] = '0; a_code[s] = '0; a_cw[s] = 1'b0;
            g_len[s] = '0; g_code[s] = '0; g_cw[s] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill a small alphabet, build it, then force a repair
        set_count(24);
        for (int s = 0; s < 24; s++) add_cmd(MODE_WRITE, s, $urandom_range(0, 9));
        add_cmd(MODE_BUILD, 0, 0);
        add_cmd(MODE_READ, 0, 0);
        add_cmd(MODE_READ, 23, 0);
        add_cmd(MODE_NONE, 511, 31);
        add_cmd(MODE_WRITE, 5, 31);
        add_cmd(MODE_WRITE, 6, 0);
        add_cmd(MODE_WRITE, 7, 16);
        add_cmd(MODE_WRITE, 8, 17);
        add_cmd(MODE_BUILD, 0, 0);
        add_cmd(MODE_READ, 5, 0);
        add_cmd(MODE_READ, 7, 0);
        add_cmd(MODE_READ, 8, 0);

        set_count(0);
        add_cmd(MODE_BUILD, 0, 0);
        add_cmd(MODE_READ, 3, 0);
        set_count(1);
        add_cmd(MODE_WRITE, 0, 1);
        add_cmd(MODE_BUILD, 0, 0);
        add_cmd(MODE_READ, 0, 0);
        add_cmd(MODE_NONE, 0, 0);

        // random phases: small alphabets, well-formed write/build/read runs plus noise
        for (int ph = 0; ph < 3; ph++) begin
            set_count($urandom_range(1, 12));
            n = (g_n > NSYM) ? NSYM : g_n;
            for (int r = 0; r < 2; r++) begin
                for (int s = 0; s < n && s < 12; s++) add_cmd(MODE_WRITE, s, rand_len());
                add_cmd(MODE_BUILD, 0, 0);
                for (int j = 0; j < 4; j++) begin
                    m = $urandom_range(0, 9);
                    if (m < 6) add_cmd(MODE_READ, $urandom_range(0, n - 1), 0);
                    else if (m < 8) add_cmd(MODE_READ, $urandom_range(0, 511), 0);
                    else if (m == 8) add_cmd(MODE_WRITE, $urandom_range(0, 511),
                                             $urandom_range(0, 31));
                    else add_cmd(MODE_NONE, $urandom_range(0, 511), $urandom_range(0, 31));
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errs == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== canonical_huffman_code_assign_unit.f =====
rtl/chca_pkg.sv
rtl/chca_ram.sv
rtl/chca_ctrl.sv
rtl/chca_dp.sv
rtl/canonical_huffman_code_assign_unit.sv
tb/tb_canonical_huffman_code_assign_unit.sv
